FILE: rtl/core/rgct_pkg.sv
// ----------------------------------------------------------------------------
// rgct_pkg: shared types and constants for the route travel time unit
// Field widths, fixed-point constants, the CORDIC arctangent table, the
// degree to binary angle conversion and the controller/datapath codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rgct_pkg;

  // Transaction field widths
  localparam int LAT_W     = 24;
  localparam int LON_W     = 25;
  localparam int LEG_W     = 23;
  localparam int HOURS_W   = 32;
  localparam int SUM_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Parameter defaults
  localparam int CORDIC_STEPS_DEF = 20;
  localparam int COUNT_BITS_DEF   = 16;

  // Internal widths: angle/CORDIC word, multiplier operand, product, counter
  localparam int AW    = 34;
  localparam int MW    = 33;
  localparam int PW    = 2 * MW;
  localparam int CNT_W = 6;
  localparam int SQ_W  = 61;

  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = SUM_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LAYOVER_TIME = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] CRUISE_SPEED_RST = 16'd800;
  localparam logic [CFG_W-1:0] LAYOVER_TIME_RST = 16'd256;

  // Binary angles, full circle is 2^32; Q30 unit equals a quarter circle
  localparam logic signed [AW-1:0] ANG_90      = 34'sh0_4000_0000;
  localparam logic signed [AW-1:0] ANG_180     = 34'sh0_8000_0000;
  localparam logic signed [AW-1:0] ANG_360     = 34'sh1_0000_0000;
  localparam logic signed [AW-1:0] Q30_ONE     = 34'sh0_4000_0000;
  localparam logic signed [AW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [LAT_W-1:0] LAT_LIMIT = 24'sd5898240;
  localparam logic signed [LON_W-1:0] LON_LIMIT = 25'sd11796480;

  // round(6371*pi*2^18) = 2^32 + RADIUS_PI_LO
  localparam logic signed [MW-1:0] RADIUS_PI_LO = 33'sd951867617;

  // ceil(2^32/45): exact floor(x/45) for x below 2^26
  localparam logic [26:0] BAM_RECIP = 27'd95443718;
  localparam logic [7:0]  BAM_INT   = 8'd182;

  localparam logic [SQ_W-1:0] SQRT_ONE_INIT = {1'b1, {(SQ_W-1){1'b0}}};

  // Controller to datapath operation codes
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BAM_A,
    OP_BAM_B,
    OP_BAM_OA,
    OP_BAM_OB,
    OP_ROT_A,
    OP_ROT_B,
    OP_ROT_D,
    OP_CORDIC_STEP,
    OP_SAVE_A,
    OP_SAVE_B,
    OP_SAVE_D,
    OP_MUL_SS,
    OP_MUL_CC,
    OP_MUL_CD,
    OP_COS,
    OP_MUL_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_VEC_INIT,
    OP_MUL_LEG,
    OP_LEG,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TOTAL,
    OP_OUT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BAM_A,
    S_BAM_B,
    S_BAM_OA,
    S_BAM_OB,
    S_ROT_A,
    S_STEP_A,
    S_SAVE_A,
    S_ROT_B,
    S_STEP_B,
    S_SAVE_B,
    S_ROT_D,
    S_STEP_D,
    S_SAVE_D,
    S_MUL_SS,
    S_MUL_CC,
    S_MUL_CD,
    S_COS,
    S_MUL_SQ,
    S_SQRT_INIT,
    S_SQRT,
    S_VEC_INIT,
    S_VEC,
    S_MUL_LEG,
    S_LEG,
    S_ACCUM,
    S_DIV_INIT,
    S_DIV,
    S_TOTAL,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic   in_ready;
    dp_op_e op;
  } ctl_cmd_t;

  typedef struct packed {
    logic leg_ok;
    logic route_end;
    logic cordic_last;
    logic sqrt_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

  // atan(2^-k) in binary angle units
  function automatic logic [31:0] atan_entry(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Degrees (1/65536) to binary angle: v*8192/45, truncated toward zero.
  // 8192 = 45*182 + 2, so |v|*8192/45 = |v|*182 + floor(2|v|/45).
  function automatic logic signed [AW-1:0] to_bam(input logic signed [LON_W-1:0] v);
    logic [LON_W-1:0] mag;
    logic [LON_W:0]   dbl;
    logic [52:0]      p;
    logic [32:0]      bam;
    mag = v[LON_W-1] ? LON_W'(-v) : LON_W'(v);
    dbl = {mag, 1'b0};
    p   = 53'(dbl) * 53'(BAM_RECIP);
    bam = 33'(mag) * 33'(BAM_INT) + 33'(p[52:32]);
    return v[LON_W-1] ? -$signed({1'b0, bam}) : $signed({1'b0, bam});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgct_stop_if.sv
// ----------------------------------------------------------------------------
// rgct_stop_if: route stop channel
// Valid/ready channel carrying one route stop per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgct_stop_if import rgct_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] stop_latitude;
  logic signed [LON_W-1:0] stop_longitude;
  logic                    route_end;

  modport source (output valid, output stop_latitude, output stop_longitude,
                  output route_end, input ready);
  modport sink   (input valid, input stop_latitude, input stop_longitude,
                  input route_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rgct_result_if.sv
// ----------------------------------------------------------------------------
// rgct_result_if: leg result channel
// Valid/ready channel carrying one leg result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgct_result_if import rgct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEG_W-1:0]   leg_distance;
  logic [HOURS_W-1:0] total_hours;
  logic               route_done;

  modport source (output valid, output leg_distance, output total_hours,
                  output route_done, input ready);
  modport sink   (input valid, input leg_distance, input total_hours,
                  input route_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rgct_datapath.sv
// ----------------------------------------------------------------------------
// rgct_datapath: arithmetic and route state
// Shared CORDIC (rotation and vectoring), shared multiplier, bit-serial
// square root and restoring divider, route accumulators and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgct_datapath import rgct_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_op_e                  op_i,
  output dp_status_t                   status_o,
  input  wire logic signed [LAT_W-1:0] lat_i,
  input  wire logic signed [LON_W-1:0] lon_i,
  input  wire logic                    end_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                    out_ready_i,
  output logic                         out_valid_o,
  output logic [LEG_W-1:0]             out_leg_o,
  output logic [HOURS_W-1:0]           out_hours_o,
  output logic                         out_done_o
);

  // Configuration and route state
  logic [CFG_W-1:0]        speed_q, layover_q;
  logic signed [LAT_W-1:0] prev_lat_q;
  logic signed [LON_W-1:0] prev_lon_q;
  logic                    have_prev_q;
  logic [COUNT_BITS-1:0]   count_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    out_valid_q;

  // Working registers
  logic signed [LAT_W-1:0] cur_lat_q;
  logic signed [LON_W-1:0] cur_lon_q;
  logic                    cur_end_q;
  logic signed [AW-1:0]    bam_q, za_q, zb_q, zd_q;
  logic                    neg_q;
  logic signed [AW-1:0]    x_q, y_q, z_q;
  logic                    vec_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [AW-1:0]    ca_q, sa_q, cb_q, sb_q, cd_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [AW-1:0]    m1_q, c_q;
  logic [SQ_W-1:0]         rem_q, res_q, one_q;
  logic [SUM_W-1:0]        dq_q;
  logic [CFG_W-1:0]        dr_q;
  logic [LEG_W-1:0]        leg_q;
  logic [HOURS_W-1:0]      total_q;
  logic [LEG_W-1:0]        out_leg_q;
  logic [HOURS_W-1:0]      out_hours_q;
  logic                    out_done_q;

  // Range check of both ends of the leg
  logic prev_in, cur_in, leg_ok;
  assign prev_in = (prev_lat_q <= LAT_LIMIT) && (prev_lat_q >= -LAT_LIMIT) &&
                   (prev_lon_q <= LON_LIMIT) && (prev_lon_q >= -LON_LIMIT);
  assign cur_in  = (cur_lat_q <= LAT_LIMIT) && (cur_lat_q >= -LAT_LIMIT) &&
                   (cur_lon_q <= LON_LIMIT) && (cur_lon_q >= -LON_LIMIT);
  assign leg_ok  = have_prev_q && prev_in && cur_in;

  // Degree to binary angle conversion, one operand per cycle
  logic signed [LON_W-1:0] bam_in;
  logic signed [AW-1:0]    bam_val;
  always_comb begin
    case (op_i)
      OP_BAM_A:  bam_in = LON_W'(prev_lat_q);
      OP_BAM_B:  bam_in = LON_W'(cur_lat_q);
      OP_BAM_OA: bam_in = prev_lon_q;
      default:   bam_in = cur_lon_q;
    endcase
  end
  assign bam_val = to_bam(bam_in);

  // Longitude difference: wrap to half circle, fold to quarter circle
  logic signed [AW-1:0] dd, dw, df;
  logic                 nf;
  always_comb begin
    dd = bam_val - bam_q;
    if (dd > ANG_180) begin
      dw = dd - ANG_360;
    end else if (dd < -ANG_180) begin
      dw = dd + ANG_360;
    end else begin
      dw = dd;
    end
    if (dw > ANG_90) begin
      df = dw - ANG_180;
      nf = 1'b1;
    end else if (dw < -ANG_90) begin
      df = dw + ANG_180;
      nf = 1'b1;
    end else begin
      df = dw;
      nf = 1'b0;
    end
  end

  // CORDIC micro-rotation
  logic [4:0]           k;
  logic signed [AW-1:0] dx, dy, at;
  logic                 sigma;
  assign k     = cnt_q[4:0];
  assign dx    = y_q >>> k;
  assign dy    = x_q >>> k;
  assign at    = $signed({2'b00, atan_entry(k)});
  assign sigma = vec_q ? y_q[AW-1] : ~z_q[AW-1];

  // Clamped arc angle
  logic [31:0] zc;
  always_comb begin
    if (z_q[AW-1]) begin
      zc = '0;
    end else if (z_q > ANG_180) begin
      zc = ANG_180[31:0];
    end else begin
      zc = z_q[31:0];
    end
  end

  // Shared multiplier operand select
  logic [COUNT_BITS-1:0] lay;
  logic signed [MW-1:0]  prod_sh, mul_a, mul_b;
  logic signed [PW-1:0]  prod_full;
  assign lay     = count_q - COUNT_BITS'(1);
  assign prod_sh = $signed(prod_q[MW+29:30]);
  always_comb begin
    case (op_i)
      OP_MUL_SS: begin
        mul_a = sa_q[MW-1:0];
        mul_b = sb_q[MW-1:0];
      end
      OP_MUL_CC: begin
        mul_a = ca_q[MW-1:0];
        mul_b = cb_q[MW-1:0];
      end
      OP_MUL_CD: begin
        mul_a = prod_sh;
        mul_b = cd_q[MW-1:0];
      end
      OP_MUL_SQ: begin
        mul_a = c_q[MW-1:0];
        mul_b = c_q[MW-1:0];
      end
      OP_MUL_LEG: begin
        mul_a = $signed({1'b0, zc});
        mul_b = RADIUS_PI_LO;
      end
      OP_DIV_INIT: begin
        mul_a = $signed({{(MW-COUNT_BITS){1'b0}}, lay});
        mul_b = $signed({{(MW-CFG_W){1'b0}}, layover_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod_full = mul_a * mul_b;

  // Central angle cosine, clamped to the unit range
  logic signed [AW-1:0] cs, cclamp;
  always_comb begin
    cs = m1_q + AW'(prod_sh);
    if (cs > Q30_ONE) begin
      cclamp = Q30_ONE;
    end else if (cs < -Q30_ONE) begin
      cclamp = -Q30_ONE;
    end else begin
      cclamp = cs;
    end
  end

  // Square root step
  logic [SQ_W:0] sq_t;
  logic          sq_ge;
  assign sq_t  = {1'b0, res_q} + {1'b0, one_q};
  assign sq_ge = {1'b0, rem_q} >= sq_t;

  // Leg rounding
  logic [64:0] leg_sum;
  assign leg_sum = 65'(prod_q[60:0]) + {1'b0, zc, 32'b0} + (65'(1) << 40);

  // Divider step
  logic [CFG_W:0] rr;
  logic           dv_ge;
  assign rr    = {dr_q, dq_q[SUM_W-1]};
  assign dv_ge = rr >= {1'b0, speed_q};

  // Accumulator update and travel time
  logic [SUM_W:0] acc;
  logic [48:0]    tsum;
  assign acc  = {1'b0, sum_q} + (SUM_W+1)'(leg_q);
  assign tsum = 49'(dq_q) + 49'(prod_q[47:0]);

  // Route state, configuration and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= CRUISE_SPEED_RST;
      layover_q   <= LAYOVER_TIME_RST;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
      have_prev_q <= 1'b0;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CRUISE_SPEED: speed_q   <= cfg_wdata_i;
          REG_LAYOVER_TIME: layover_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (op_i == OP_ACCUM) begin
        sum_q       <= acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        if (count_q != '1) begin
          count_q <= count_q + COUNT_BITS'(1);
        end
        prev_lat_q  <= cur_lat_q;
        prev_lon_q  <= cur_lon_q;
        have_prev_q <= 1'b1;
      end
      if (op_i == OP_OUT) begin
        out_valid_q <= 1'b1;
        if (cur_end_q) begin
          prev_lat_q  <= '0;
          prev_lon_q  <= '0;
          have_prev_q <= 1'b0;
          count_q     <= '0;
          sum_q       <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers, sequenced by the controller
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        cur_lat_q <= lat_i;
        cur_lon_q <= lon_i;
        cur_end_q <= end_i;
        leg_q     <= '0;
        total_q   <= '0;
      end
      OP_BAM_A:  za_q  <= bam_val;
      OP_BAM_B:  zb_q  <= bam_val;
      OP_BAM_OA: bam_q <= bam_val;
      OP_BAM_OB: begin
        zd_q  <= df;
        neg_q <= nf;
      end
      OP_ROT_A, OP_ROT_B, OP_ROT_D: begin
        x_q   <= CORDIC_GAIN;
        y_q   <= '0;
        vec_q <= 1'b0;
        cnt_q <= '0;
        if (op_i == OP_ROT_A) begin
          z_q <= za_q;
        end else if (op_i == OP_ROT_B) begin
          z_q <= zb_q;
        end else begin
          z_q <= zd_q;
        end
      end
      OP_CORDIC_STEP: begin
        if (sigma) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_SAVE_A: begin
        ca_q <= x_q;
        sa_q <= y_q;
      end
      OP_SAVE_B: begin
        cb_q <= x_q;
        sb_q <= y_q;
      end
      OP_SAVE_D: cd_q <= neg_q ? -x_q : x_q;
      OP_MUL_SS: prod_q <= prod_full;
      OP_MUL_CC: begin
        m1_q   <= AW'(prod_sh);
        prod_q <= prod_full;
      end
      OP_MUL_CD: prod_q <= prod_full;
      OP_COS:    c_q    <= cclamp;
      OP_MUL_SQ: prod_q <= prod_full;
      OP_SQRT_INIT: begin
        rem_q <= SQRT_ONE_INIT - prod_q[SQ_W-1:0];
        res_q <= '0;
        one_q <= SQRT_ONE_INIT;
        cnt_q <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_ge) begin
          rem_q <= rem_q - sq_t[SQ_W-1:0];
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
        one_q <= one_q >> 2;
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_VEC_INIT: begin
        vec_q <= 1'b1;
        cnt_q <= '0;
        if (c_q[AW-1]) begin
          x_q <= $signed({1'b0, res_q[AW-2:0]});
          y_q <= -c_q;
          z_q <= ANG_90;
        end else begin
          x_q <= c_q;
          y_q <= $signed({1'b0, res_q[AW-2:0]});
          z_q <= '0;
        end
      end
      OP_MUL_LEG: prod_q <= prod_full;
      OP_LEG:     leg_q  <= leg_sum[63:41];
      OP_DIV_INIT: begin
        dq_q   <= sum_q;
        dr_q   <= '0;
        cnt_q  <= '0;
        prod_q <= prod_full;
      end
      OP_DIV_STEP: begin
        dr_q  <= dv_ge ? CFG_W'(rr - {1'b0, speed_q}) : rr[CFG_W-1:0];
        dq_q  <= {dq_q[SUM_W-2:0], dv_ge};
        cnt_q <= cnt_q + CNT_W'(1);
      end
      OP_TOTAL: begin
        if (speed_q == '0 || tsum[48:32] != '0) begin
          total_q <= '1;
        end else begin
          total_q <= tsum[31:0];
        end
      end
      OP_OUT: begin
        out_leg_q   <= leg_q;
        out_hours_q <= total_q;
        out_done_q  <= cur_end_q;
      end
      default: ;
    endcase
  end

  // Status back to the controller
  assign status_o.leg_ok      = leg_ok;
  assign status_o.route_end   = cur_end_q;
  assign status_o.cordic_last = cnt_q == CNT_W'(CORDIC_STEPS - 1);
  assign status_o.sqrt_last   = cnt_q == CNT_W'(SQRT_STEPS - 1);
  assign status_o.div_last    = cnt_q == CNT_W'(DIV_STEPS - 1);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_leg_o   = out_leg_q;
  assign out_hours_o = out_hours_q;
  assign out_done_o  = out_done_q;

endmodule

`default_nettype wire

FILE: rtl/core/rgct_controller.sv
// ----------------------------------------------------------------------------
// rgct_controller: sequencer for one route stop
// Walks the datapath through conversion, three rotations, the cosine
// products, square root, arc vectoring, accumulation and the route total.
// ----------------------------------------------------------------------------
`default_nettype none

module rgct_controller import rgct_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire dp_status_t status_i,
  output ctl_cmd_t        cmd_o
);

  ctl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_BAM_A;
      S_BAM_A:     state_d = status_i.leg_ok ? S_BAM_B : S_ACCUM;
      S_BAM_B:     state_d = S_BAM_OA;
      S_BAM_OA:    state_d = S_BAM_OB;
      S_BAM_OB:    state_d = S_ROT_A;
      S_ROT_A:     state_d = S_STEP_A;
      S_STEP_A:    if (status_i.cordic_last) state_d = S_SAVE_A;
      S_SAVE_A:    state_d = S_ROT_B;
      S_ROT_B:     state_d = S_STEP_B;
      S_STEP_B:    if (status_i.cordic_last) state_d = S_SAVE_B;
      S_SAVE_B:    state_d = S_ROT_D;
      S_ROT_D:     state_d = S_STEP_D;
      S_STEP_D:    if (status_i.cordic_last) state_d = S_SAVE_D;
      S_SAVE_D:    state_d = S_MUL_SS;
      S_MUL_SS:    state_d = S_MUL_CC;
      S_MUL_CC:    state_d = S_MUL_CD;
      S_MUL_CD:    state_d = S_COS;
      S_COS:       state_d = S_MUL_SQ;
      S_MUL_SQ:    state_d = S_SQRT_INIT;
      S_SQRT_INIT: state_d = S_SQRT;
      S_SQRT:      if (status_i.sqrt_last) state_d = S_VEC_INIT;
      S_VEC_INIT:  state_d = S_VEC;
      S_VEC:       if (status_i.cordic_last) state_d = S_MUL_LEG;
      S_MUL_LEG:   state_d = S_LEG;
      S_LEG:       state_d = S_ACCUM;
      S_ACCUM:     state_d = status_i.route_end ? S_DIV_INIT : S_OUT;
      S_DIV_INIT:  state_d = S_DIV;
      S_DIV:       if (status_i.div_last) state_d = S_TOTAL;
      S_TOTAL:     state_d = S_OUT;
      S_OUT:       if (status_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o.in_ready = 1'b0;
    cmd_o.op       = OP_NONE;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_BAM_A:     cmd_o.op = OP_BAM_A;
      S_BAM_B:     cmd_o.op = OP_BAM_B;
      S_BAM_OA:    cmd_o.op = OP_BAM_OA;
      S_BAM_OB:    cmd_o.op = OP_BAM_OB;
      S_ROT_A:     cmd_o.op = OP_ROT_A;
      S_ROT_B:     cmd_o.op = OP_ROT_B;
      S_ROT_D:     cmd_o.op = OP_ROT_D;
      S_STEP_A,
      S_STEP_B,
      S_STEP_D,
      S_VEC:       cmd_o.op = OP_CORDIC_STEP;
      S_SAVE_A:    cmd_o.op = OP_SAVE_A;
      S_SAVE_B:    cmd_o.op = OP_SAVE_B;
      S_SAVE_D:    cmd_o.op = OP_SAVE_D;
      S_MUL_SS:    cmd_o.op = OP_MUL_SS;
      S_MUL_CC:    cmd_o.op = OP_MUL_CC;
      S_MUL_CD:    cmd_o.op = OP_MUL_CD;
      S_COS:       cmd_o.op = OP_COS;
      S_MUL_SQ:    cmd_o.op = OP_MUL_SQ;
      S_SQRT_INIT: cmd_o.op = OP_SQRT_INIT;
      S_SQRT:      cmd_o.op = OP_SQRT_STEP;
      S_VEC_INIT:  cmd_o.op = OP_VEC_INIT;
      S_MUL_LEG:   cmd_o.op = OP_MUL_LEG;
      S_LEG:       cmd_o.op = OP_LEG;
      S_ACCUM:     cmd_o.op = OP_ACCUM;
      S_DIV_INIT:  cmd_o.op = OP_DIV_INIT;
      S_DIV:       cmd_o.op = OP_DIV_STEP;
      S_TOTAL:     cmd_o.op = OP_TOTAL;
      S_OUT:       if (status_i.out_free) cmd_o.op = OP_OUT;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/route_great_circle_travel_time_unit.sv
// Route travel time unit. Takes one route stop per transaction and returns
// one result per stop: the great-circle length of the leg from the previous
// stop (law of cosines, Earth radius 6371 km, 1/256 km), and on the stop
// flagged as route end the total time in 1/256 h, after which the route
// state is cleared. Stops are handled one at a time. A stop that closes a
// valid leg runs three sine/cosine rotations and one arc-cosine vectoring
// run on a single shared CORDIC plus a 31-step square root; a first stop
// or a leg with a coordinate out of range skips these and gives a zero
// leg; a route end adds the 32-step division by cruise speed. The next
// stop is taken while a finished result still waits in the output
// register. Configuration writes are taken at any time and belong to
// idle periods.
// ----------------------------------------------------------------------------
// route_great_circle_travel_time_unit: top level
// Joins the sequencer and the datapath to the stop and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module route_great_circle_travel_time_unit import rgct_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  rgct_stop_if.sink                 stop_i,
  rgct_result_if.source             result_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign stop_i.ready = cmd.in_ready;

  rgct_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (stop_i.valid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rgct_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (cmd.op),
    .status_o    (status),
    .lat_i       (stop_i.stop_latitude),
    .lon_i       (stop_i.stop_longitude),
    .end_i       (stop_i.route_end),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (result_o.ready),
    .out_valid_o (result_o.valid),
    .out_leg_o   (result_o.leg_distance),
    .out_hours_o (result_o.total_hours),
    .out_done_o  (result_o.route_done)
  );

endmodule

`default_nettype wire
